// File: hdl/rgb_led_strip_serializer_macros.svh
// Assertion macros shared by the serializer RTL.
`ifndef RGB_LED_STRIP_SERIALIZER_MACROS_SVH
`define RGB_LED_STRIP_SERIALIZER_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, held off during reset.
`define RLSS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rlss: check failed");
// Next-cycle implication, held off during reset.
`define RLSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rlss: check failed");
`else
`define RLSS_ASSERT_NOW(label, clk, rst, ante, cons)
`define RLSS_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// File: hdl/rlss_pkg.sv
// Types, constants and helpers shared by the serializer modules.
package rlss_pkg;

  localparam int QUEUE_DEPTH    = 2;
  localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W         = $clog2(QUEUE_DEPTH + 1);
  localparam int BITS_PER_PIXEL = 24;
  localparam int BIT_CNT_W      = $clog2(BITS_PER_PIXEL);
  localparam int CFG_IDX_W      = 3;
  localparam int CFG_DATA_W     = 16;

  localparam logic [1:0] KIND_ZERO  = 2'd0;
  localparam logic [1:0] KIND_ONE   = 2'd1;
  localparam logic [1:0] KIND_RESET = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BRIGHTNESS = 3'd0,
    REG_ZERO_HIGH  = 3'd1,
    REG_ZERO_LOW   = 3'd2,
    REG_ONE_HIGH   = 3'd3,
    REG_ONE_LOW    = 3'd4,
    REG_LATCH_LOW  = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DATA,
    BK_LATCH
  } back_state_t;

  // One queued pixel: scaled GRB word and end-of-frame flag.
  typedef struct packed {
    logic [BITS_PER_PIXEL-1:0] word;
    logic                      last;
  } pix_word_t;

  typedef struct packed {
    logic      valid;
    pix_word_t data;
  } q_beat_t;

  typedef struct packed {
    logic [9:0]  zero_high;
    logic [9:0]  zero_low;
    logic [9:0]  one_high;
    logic [9:0]  one_low;
    logic [15:0] latch_low;
  } tick_cfg_t;

  // floor(p / 255) for any product of two bytes: add the high byte and one, keep the high byte.
  function automatic logic [7:0] div255(input logic [15:0] p);
    logic [16:0] s;
    s = {1'b0, p} + {9'd0, p[15:8]} + 17'd1;
    return s[15:8];
  endfunction

endpackage

// File: hdl/rlss_if.sv
// Channel interfaces: pixel input, symbol output and register writes.
interface rlss_pixel_if
  import rlss_pkg::*;
();
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;
  logic       last_pixel;

  modport source (output valid, red, green, blue, last_pixel, input ready);
  modport sink   (input valid, red, green, blue, last_pixel, output ready);
endinterface

interface rlss_symbol_if
  import rlss_pkg::*;
();
  logic        valid;
  logic        ready;
  logic [1:0]  symbol_kind;
  logic [9:0]  high_time;
  logic [15:0] low_time;
  logic        last_symbol;

  modport source (output valid, symbol_kind, high_time, low_time, last_symbol, input ready);
  modport sink   (input valid, symbol_kind, high_time, low_time, last_symbol, output ready);
endinterface

interface rlss_cfg_if
  import rlss_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// File: hdl/rlss_front.sv
// Front end: accept pixels, multiply by brightness, scale and push to the queue.
module rlss_front
  import rlss_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  rlss_pixel_if.sink   pixel,
  input  logic [7:0]   brightness,
  output q_beat_t      q_wr,
  input  logic         q_ready
);

  logic        s1_valid;
  logic [15:0] prod_r;
  logic [15:0] prod_g;
  logic [15:0] prod_b;
  logic        s1_last;

  // Advance the product stage whenever it is empty or drains into the queue.
  assign pixel.ready = !s1_valid || q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (pixel.ready) begin
      s1_valid <= pixel.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (pixel.ready && pixel.valid) begin
      prod_r  <= {8'd0, pixel.red} * {8'd0, brightness};
      prod_g  <= {8'd0, pixel.green} * {8'd0, brightness};
      prod_b  <= {8'd0, pixel.blue} * {8'd0, brightness};
      s1_last <= pixel.last_pixel;
    end
  end

  always_comb begin
    q_wr.valid     = s1_valid;
    q_wr.data.word = {div255(prod_g), div255(prod_r), div255(prod_b)};
    q_wr.data.last = s1_last;
  end

endmodule

// File: hdl/rlss_queue.sv
// Short pixel queue between the front end and the serializer.
module rlss_queue
  import rlss_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  q_beat_t   q_wr,
  output logic      q_ready,
  output logic      q_valid,
  output pix_word_t q_data,
  input  logic      q_pop
);

  pix_word_t           slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCNT_W-1:0]   count;
  logic                push;

  assign q_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign q_valid = count != '0;
  assign q_data  = slots[rd_ptr];
  assign push    = q_wr.valid && q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (q_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !q_pop) begin
        count <= count + 1'b1;
      end else if (!push && q_pop) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= q_wr.data;
    end
  end

endmodule

// File: hdl/rlss_back.sv
// Back end: turn queued pixels into line symbols, one per cycle while the symbol output is not stalled.
module rlss_back
  import rlss_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         q_valid,
  input  pix_word_t    q_data,
  output logic         q_pop,
  input  tick_cfg_t    ticks,
  rlss_symbol_if.source symbol
);

  back_state_t               state;
  back_state_t               state_next;
  logic [BITS_PER_PIXEL-1:0] word;
  logic [BIT_CNT_W-1:0]      cnt;
  logic                      last;

  logic [BITS_PER_PIXEL-1:0] src_word;
  logic [BIT_CNT_W-1:0]      src_cnt;
  logic                      src_last;
  logic                      out_free;
  logic                      emit_data;
  logic                      emit_latch;
  logic                      final_bit;

  logic [1:0]  kind_d;
  logic [9:0]  high_d;
  logic [15:0] low_d;
  logic        last_d;

  // In IDLE the first bit comes straight from the queue head.
  assign src_word  = (state == BK_DATA) ? word : q_data.word;
  assign src_cnt   = (state == BK_DATA) ? cnt  : '0;
  assign src_last  = (state == BK_DATA) ? last : q_data.last;
  assign out_free  = !symbol.valid || symbol.ready;
  assign final_bit = src_cnt == BIT_CNT_W'(BITS_PER_PIXEL - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    emit_data  = 1'b0;
    emit_latch = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (out_free && q_valid) begin
          q_pop     = 1'b1;
          emit_data = 1'b1;
        end
      end
      BK_DATA: begin
        emit_data = out_free;
      end
      BK_LATCH: begin
        if (out_free) begin
          emit_latch = 1'b1;
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
    if (emit_data) begin
      if (!final_bit) begin
        state_next = BK_DATA;
      end else if (src_last) begin
        state_next = BK_LATCH;
      end else begin
        state_next = BK_IDLE;
      end
    end
  end

  always_comb begin
    if (emit_latch) begin
      kind_d = KIND_RESET;
      high_d = '0;
      low_d  = ticks.latch_low;
      last_d = 1'b1;
    end else if (src_word[BITS_PER_PIXEL-1]) begin
      kind_d = KIND_ONE;
      high_d = ticks.one_high;
      low_d  = {6'd0, ticks.one_low};
      last_d = final_bit && !src_last;
    end else begin
      kind_d = KIND_ZERO;
      high_d = ticks.zero_high;
      low_d  = {6'd0, ticks.zero_low};
      last_d = final_bit && !src_last;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_data) begin
      word <= {src_word[BITS_PER_PIXEL-2:0], 1'b0};
      cnt  <= src_cnt + 1'b1;
      last <= src_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      symbol.valid <= 1'b0;
    end else if (emit_data || emit_latch) begin
      symbol.valid <= 1'b1;
    end else if (symbol.ready) begin
      symbol.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_data || emit_latch) begin
      symbol.symbol_kind <= kind_d;
      symbol.high_time   <= high_d;
      symbol.low_time    <= low_d;
      symbol.last_symbol <= last_d;
    end
  end

endmodule

// File: hdl/rgb_led_strip_serializer.sv
// Top level of the LED strip serializer: registers, front end, queue, back end.
//
//  channel  dir  beat contents
//  -------  ---  ---------------------------------------------------------
//  pixel    in   red, green, blue (8 b each), last_pixel
//  symbol   out  symbol_kind (2 b), high_time (10 b), low_time (16 b), last_symbol
//  cfg      in   index (3 b), data (16 b); always ready
//
//  A pixel becomes 24 symbol beats, 25 when it ends a frame: the back end emits
//  one symbol beat per cycle from its output register unless the output stalls.
//  The front end multiplies in one registered stage and scales into a 2-deep
//  queue, so pixels are taken while the serializer is busy with earlier ones.
//  Reset is synchronous; registers return to their power-up tick values.
//  A stalled symbol beat holds in the output register; the queue soaks up stalls.
module rgb_led_strip_serializer
  import rlss_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  rlss_pixel_if.sink    pixel,
  rlss_symbol_if.source symbol,
  rlss_cfg_if.sink      cfg
);

`include "rgb_led_strip_serializer_macros.svh"

  logic [7:0] brightness;
  tick_cfg_t  ticks;
  q_beat_t    q_wr;
  logic       q_ready;
  logic       q_valid;
  pix_word_t  q_data;
  logic       q_pop;

  // Register writes always complete; drop indexes beyond the list.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness      <= 8'd255;
      ticks.zero_high <= 10'd15;
      ticks.zero_low  <= 10'd30;
      ticks.one_high  <= 10'd30;
      ticks.one_low   <= 10'd20;
      ticks.latch_low <= 16'd2880;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_BRIGHTNESS: brightness      <= cfg.data[7:0];
        REG_ZERO_HIGH:  ticks.zero_high <= cfg.data[9:0];
        REG_ZERO_LOW:   ticks.zero_low  <= cfg.data[9:0];
        REG_ONE_HIGH:   ticks.one_high  <= cfg.data[9:0];
        REG_ONE_LOW:    ticks.one_low   <= cfg.data[9:0];
        REG_LATCH_LOW:  ticks.latch_low <= cfg.data;
        default: ;
      endcase
    end
  end

  rlss_front u_front (
    .clk        (clk),
    .rst        (rst),
    .pixel      (pixel),
    .brightness (brightness),
    .q_wr       (q_wr),
    .q_ready    (q_ready)
  );

  rlss_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .q_wr    (q_wr),
    .q_ready (q_ready),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop)
  );

  rlss_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_data  (q_data),
    .q_pop   (q_pop),
    .ticks   (ticks),
    .symbol  (symbol)
  );

  // Pop only a filled queue.
  `RLSS_ASSERT_NOW(a_pop_nonempty, clk, rst, q_pop, q_valid)
  // A reset pulse beat has no high part and closes its pixel.
  `RLSS_ASSERT_NOW(a_latch_shape, clk, rst,
    symbol.valid && symbol.symbol_kind == KIND_RESET,
    symbol.high_time == 10'd0 && symbol.last_symbol)
  // A pop always loads a new symbol beat into the output register.
  `RLSS_ASSERT_NEXT(a_pop_shows, clk, rst, q_pop, symbol.valid)

endmodule

// File: verif/rgb_led_strip_serializer_tb.sv
// Self-checking testbench for the LED strip serializer: random pixels and settings.
`timescale 1ns / 1ps

module rgb_led_strip_serializer_tb;
  import rlss_pkg::*;

  // Unmapped register indexes: writes there must leave every setting alone.
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_LO = CFG_IDX_W'(REG_LATCH_LOW + 1);
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED_HI = '1;

  localparam int CYCLE_LIMIT   = 400_000;
  localparam int DRAIN_CYCLES  = 64;
  localparam int MAX_REPORTS   = 30;
  localparam int RANDOM_PHASES = 6;
  localparam int RANDOM_PIXELS = 413;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } pixel_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [9:0]  high;
    logic [15:0] low;
    logic        last;
  } symbol_beat_t;

  logic clk;
  logic rst;

  rlss_pixel_if  pix_if ();
  rlss_symbol_if sym_if ();
  rlss_cfg_if    cfg_if ();

  rgb_led_strip_serializer uut (
    .clk    (clk),
    .rst    (rst),
    .pixel  (pix_if),
    .symbol (sym_if),
    .cfg    (cfg_if)
  );

  // Shadow copy of the register file, updated on every accepted write beat.
  logic [7:0] shadow_brightness;
  tick_cfg_t  shadow_ticks;

  pixel_t       pixel_queue[$];   // pixels waiting to be offered, front is on the bus
  symbol_beat_t symbols_due[$];   // symbol beats predicted but not yet seen

  int  send_idle_pct;
  int  recv_idle_pct;
  bit  pixel_taken;
  int  cycle_count;
  int  mismatches;
  int  pixels_seen;
  int  frames_seen;
  int  symbols_seen;
  int  ones_seen;
  int  settings_applied;

  // 10 ns clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Bail out if the block hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d symbol beats still due",
               $time, cycle_count, symbols_due.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Scale one channel by brightness: floor(c * brightness / 255).
  function automatic logic [7:0] scale_channel(input logic [7:0] c);
    logic [15:0] product;
    product = {8'd0, c} * {8'd0, shadow_brightness};
    return 8'(product / 16'd255);
  endfunction

  // Expand one pixel into its GRB bit symbols, MSB first, plus the latch
  // symbol when the pixel closes a frame.
  task automatic queue_symbols(input pixel_t p);
    logic [23:0]  grb;
    symbol_beat_t s;
    grb = {scale_channel(p.green), scale_channel(p.red), scale_channel(p.blue)};
    for (int i = 23; i >= 0; i--) begin
      if (grb[i]) begin
        s.kind = KIND_ONE;
        s.high = shadow_ticks.one_high;
        s.low  = {6'd0, shadow_ticks.one_low};
      end else begin
        s.kind = KIND_ZERO;
        s.high = shadow_ticks.zero_high;
        s.low  = {6'd0, shadow_ticks.zero_low};
      end
      // last_symbol marks the final beat of this pixel; with a latch to
      // follow, that honour moves to the latch beat.
      s.last = (i == 0) && !p.last;
      symbols_due.push_back(s);
    end
    if (p.last) begin
      s.kind = KIND_RESET;
      s.high = 10'd0;
      s.low  = shadow_ticks.latch_low;
      s.last = 1'b1;
      symbols_due.push_back(s);
    end
  endtask

  // Mirror a register write; unmapped indexes drop, wide data is truncated.
  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_BRIGHTNESS: shadow_brightness      = value[7:0];
      REG_ZERO_HIGH:  shadow_ticks.zero_high = value[9:0];
      REG_ZERO_LOW:   shadow_ticks.zero_low  = value[9:0];
      REG_ONE_HIGH:   shadow_ticks.one_high  = value[9:0];
      REG_ONE_LOW:    shadow_ticks.one_low   = value[9:0];
      REG_LATCH_LOW:  shadow_ticks.latch_low = value;
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Pixel driver: offer the front of the queue, hold it until a beat is taken
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst) begin
      pix_if.valid <= 1'b0;
    end else if (!pix_if.valid || pixel_taken) begin
      if (pixel_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        pix_if.valid      <= 1'b1;
        pix_if.red        <= pixel_queue[0].red;
        pix_if.green      <= pixel_queue[0].green;
        pix_if.blue       <= pixel_queue[0].blue;
        pix_if.last_pixel <= pixel_queue[0].last;
      end else begin
        pix_if.valid <= 1'b0;
      end
    end
    pixel_taken = 1'b0;
  end

  // Symbol sink: stall at random, at the rate of the current phase.
  always @(negedge clk) begin
    if (rst) begin
      sym_if.ready <= 1'b0;
    end else begin
      sym_if.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: predict on pixel beats, check on symbol beats
  // ---------------------------------------------------------------------------
  task automatic report_field(input string name, input int expv, input int gotv);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: symbol beat %0d, %s expected %0d, got %0d",
               $time, symbols_seen, name, expv, gotv);
  endtask

  always @(posedge clk) begin
    pixel_t       p;
    symbol_beat_t got;
    symbol_beat_t want;
    if (!rst) begin
      if (pix_if.valid && pix_if.ready) begin
        p.red   = pix_if.red;
        p.green = pix_if.green;
        p.blue  = pix_if.blue;
        p.last  = pix_if.last_pixel;
        queue_symbols(p);
        void'(pixel_queue.pop_front());
        pixel_taken = 1'b1;
        pixels_seen++;
        if (p.last)
          frames_seen++;
      end
      if (sym_if.valid && sym_if.ready) begin
        got.kind = sym_if.symbol_kind;
        got.high = sym_if.high_time;
        got.low  = sym_if.low_time;
        got.last = sym_if.last_symbol;
        if (symbols_due.size() == 0) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("%0t: symbol beat with nothing expected, got kind %0d high %0d low %0d last %0d",
                     $time, got.kind, got.high, got.low, got.last);
        end else begin
          want = symbols_due.pop_front();
          if (got.kind !== want.kind)
            report_field("symbol_kind", int'(want.kind), int'(got.kind));
          if (got.high !== want.high)
            report_field("high_time", int'(want.high), int'(got.high));
          if (got.low  !== want.low)
            report_field("low_time", int'(want.low), int'(got.low));
          if (got.last !== want.last)
            report_field("last_symbol", int'(want.last), int'(got.last));
        end
        if (got.kind == KIND_ONE)
          ones_seen++;
        symbols_seen++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencing helpers
  // ---------------------------------------------------------------------------

  // One write beat on the register channel; hold until it is taken.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= value;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    apply_reg(idx, value);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [15:0] br, input logic [15:0] zh,
                               input logic [15:0] zl, input logic [15:0] oh,
                               input logic [15:0] ol, input logic [15:0] lt);
    write_reg(REG_BRIGHTNESS, br);
    write_reg(REG_ZERO_HIGH, zh);
    write_reg(REG_ZERO_LOW, zl);
    write_reg(REG_ONE_HIGH, oh);
    write_reg(REG_ONE_LOW, ol);
    write_reg(REG_LATCH_LOW, lt);
    settings_applied++;
  endtask

  // Block until every queued pixel is in and every predicted beat is out.
  task automatic wait_idle();
    while (pixel_queue.size() != 0 || symbols_due.size() != 0) @(negedge clk);
  endtask

  task automatic push_pixel(input logic [7:0] r, input logic [7:0] g,
                            input logic [7:0] b, input logic last);
    pixel_t p;
    p.red   = r;
    p.green = g;
    p.blue  = b;
    p.last  = last;
    pixel_queue.push_back(p);
  endtask

  // Channel value leaning towards the ends of the range now and then.
  function automatic logic [7:0] pick_channel();
    case ($urandom_range(0, 7))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  // Tick value: extremes, zero, over-wide data or anything in range.
  function automatic logic [15:0] pick_ticks();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd1023;
      3:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(1, 1023));
    endcase
  endfunction

  function automatic logic [15:0] pick_brightness();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'd255;
      3:       return 16'($urandom_range(0, 65535));
      default: return 16'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [15:0] pick_latch();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  initial begin
    int phase_pixels;
    int mode;

    // Known levels on every input from time zero.
    rst               = 1'b1;
    pix_if.valid      = 1'b0;
    pix_if.red        = '0;
    pix_if.green      = '0;
    pix_if.blue       = '0;
    pix_if.last_pixel = 1'b0;
    sym_if.ready      = 1'b0;
    cfg_if.valid      = 1'b0;
    cfg_if.index      = REG_BRIGHTNESS;
    cfg_if.data       = '0;
    pixel_taken       = 1'b0;
    send_idle_pct     = 14;
    recv_idle_pct     = 70;

    // Power-up register values.
    shadow_brightness      = 8'd255;
    shadow_ticks.zero_high = 10'd15;
    shadow_ticks.zero_low  = 10'd30;
    shadow_ticks.one_high  = 10'd30;
    shadow_ticks.one_low   = 10'd20;
    shadow_ticks.latch_low = 16'd2880;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: power-up settings, channel extremes and bit patterns,
    // frames of several pixels.
    push_pixel(8'h00, 8'h00, 8'h00, 1'b0);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
    push_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
    push_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
    push_pixel(8'hAA, 8'h55, 8'h81, 1'b0);
    push_pixel(8'h01, 8'h80, 8'h7F, 1'b1);
    push_pixel(8'h12, 8'h34, 8'h56, 1'b0);
    wait_idle();

    // Zero brightness blanks every channel; tick registers at zero and at
    // full scale, latch of zero. Writes to unmapped indexes must be dropped.
    load_settings(16'd0, 16'd0, 16'd1023, 16'd1023, 16'd0, 16'd0);
    write_reg(REG_UNMAPPED_LO, 16'hFFFF);
    write_reg(REG_UNMAPPED_HI, 16'h0000);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
    push_pixel(8'h80, 8'hC8, 8'h03, 1'b0);
    push_pixel(8'h00, 8'h00, 8'h00, 1'b1);
    wait_idle();

    // Over-wide data: only the low bits of each register survive.
    load_settings(16'hFF80, 16'hFFFF, 16'h0401, 16'd1, 16'hFC00, 16'hFFFF);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    push_pixel(8'h01, 8'h02, 8'h03, 1'b1);
    push_pixel(8'hFE, 8'h7F, 8'h40, 1'b1);
    push_pixel(8'hFF, 8'h00, 8'hFF, 1'b0);
    wait_idle();

    // Brightness of one: only a full-scale channel keeps a set bit.
    write_reg(REG_BRIGHTNESS, 16'd1);
    push_pixel(8'hFF, 8'hFE, 8'h00, 1'b1);
    push_pixel(8'hFF, 8'hFF, 8'hFF, 1'b0);
    wait_idle();

    // Random phases: fresh settings each time, idling pattern per pair.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      mode = phase / 2;
      send_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 70 : 0;
      recv_idle_pct = (mode == 0) ? 70 : (mode == 1) ? 14 : 0;
      load_settings(pick_brightness(), pick_ticks(), pick_ticks(), pick_ticks(),
                    pick_ticks(), pick_latch());
      if ($urandom_range(0, 1))
        write_reg(CFG_IDX_W'($urandom_range(REG_UNMAPPED_LO, REG_UNMAPPED_HI)),
                  CFG_DATA_W'($urandom_range(0, 65535)));
      phase_pixels = RANDOM_PIXELS / RANDOM_PHASES;
      if (phase == RANDOM_PHASES - 1)
        phase_pixels = RANDOM_PIXELS - phase_pixels * (RANDOM_PHASES - 1);
      repeat (phase_pixels)
        push_pixel(pick_channel(), pick_channel(), pick_channel(),
                   $urandom_range(0, 3) == 0);
      wait_idle();
    end

    // Let any stray beats surface before judging.
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Serialized %0d pixels in %0d frames into %0d symbol beats (%0d ones),",
             pixels_seen, frames_seen, symbols_seen, ones_seen);
    $display("over %0d register settings and three idling patterns, in %0d cycles.",
             settings_applied, cycle_count);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
